// File: rtl/hst_pkg.sv
// Shared types, constants and width helpers for the Helmert transform unit.
`default_nettype none
package hst_pkg;

  localparam int SCALE_FRAC_BITS = 30;
  localparam logic [31:0] SCALE_ONE = 32'h4000_0000;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_SATURATED  = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SCALE = 2'd2;
  localparam logic [1:0] STATUS_UNUSED     = 2'd3;

  typedef enum logic [2:0] {
    REG_SHIFT_X = 3'd0,
    REG_SHIFT_Y = 3'd1,
    REG_SHIFT_Z = 3'd2,
    REG_TURN_X  = 3'd3,
    REG_TURN_Y  = 3'd4,
    REG_TURN_Z  = 3'd5,
    REG_SCALE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] shift_x;
    logic [31:0] shift_y;
    logic [31:0] shift_z;
    logic [31:0] turn_x;
    logic [31:0] turn_y;
    logic [31:0] turn_z;
    logic [31:0] scale_factor;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic inverse;
    logic zero_scale;
  } item_ctl_t;

  function automatic int max_of(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // Signed width of one adjugate entry.
  function automatic int adj_width(int a);
    return max_of(max_of(2 * a, a + 33), 62) + 3;
  endfunction

  // Signed width of the rotated forward position.
  function automatic int rot_width(int p, int a);
    return p + max_of(a, 32) + 2;
  endfunction

  // Unsigned width of the determinant.
  function automatic int det_width(int a);
    return max_of(2 * a, 62) + 3;
  endfunction

  // Signed width of a numerator handed to the divider.
  function automatic int num_width(int p, int a);
    int nfw;
    int niw;
    nfw = max_of(rot_width(p, a) + 33, 62 + a) + 1;
    niw = adj_width(a) + p + 1 + 2 + SCALE_FRAC_BITS;
    return max_of(nfw, niw) + 1;
  endfunction

  // Unsigned width of the denominator handed to the divider.
  function automatic int den_width(int a);
    return max_of(det_width(a) + 32, SCALE_FRAC_BITS + a + 1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/hst_mul.sv
// Pipelined signed multiplier built from registered 32x32 limb products.
`default_nettype none
module hst_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  wire logic                    clk,
  input  wire logic signed [WA-1:0]    a,
  input  wire logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0]      p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int RW = (NA + NB) * 32;

  logic [NA*32-1:0] amag_r;
  logic [NB*32-1:0] bmag_r;
  logic             neg1_r;
  logic [63:0]      pp_r [NA][NB];
  logic             neg2_r;
  logic [RW-1:0]    sum_nxt;
  logic [RW-1:0]    sum_r;
  logic             neg3_r;
  logic signed [WA+WB-1:0] p_r;

  // Stage 1: magnitudes and product sign.
  always_ff @(posedge clk) begin
    amag_r <= (NA*32)'($unsigned(a[WA-1] ? -a : a));
    bmag_r <= (NB*32)'($unsigned(b[WB-1] ? -b : b));
    neg1_r <= a[WA-1] ^ b[WB-1];
  end

  // Stage 2: limb products.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= amag_r[32*i +: 32] * bmag_r[32*j +: 32];
      end
    end
    neg2_r <= neg1_r;
  end

  // Stage 3: sum of the aligned partial products.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (RW'(pp_r[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    neg3_r <= neg2_r;
  end

  // Stage 4: restore the sign.
  always_ff @(posedge clk) begin
    p_r <= neg3_r ? -$signed(sum_r[WA+WB-1:0]) : $signed(sum_r[WA+WB-1:0]);
  end

  assign p = p_r;

endmodule
`default_nettype wire

// File: rtl/hst_front.sv
// Front end: configuration registers, request acceptance and classification.
`default_nettype none
module hst_front #(
  parameter int P = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  start,
  input  wire logic                  q_full,
  input  wire logic                  in_action,
  input  wire logic signed [P-1:0]   in_p [3],
  output logic                       busy,
  output hst_pkg::cfg_t              cfg,
  output hst_pkg::item_ctl_t         push_ctl,
  output logic signed [P-1:0]        push_p [3]
);

  hst_pkg::cfg_t      cfg_r;
  hst_pkg::item_ctl_t ctl_r;
  logic signed [P-1:0] p_r [3];
  logic               accept;

  assign busy   = q_full;
  assign accept = start && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{shift_x: '0, shift_y: '0, shift_z: '0, turn_x: '0, turn_y: '0,
                 turn_z: '0, scale_factor: hst_pkg::SCALE_ONE};
    end else if (cfg_wr_en) begin
      unique case (hst_pkg::reg_idx_t'(cfg_index))
        hst_pkg::REG_SHIFT_X: cfg_r.shift_x      <= cfg_data;
        hst_pkg::REG_SHIFT_Y: cfg_r.shift_y      <= cfg_data;
        hst_pkg::REG_SHIFT_Z: cfg_r.shift_z      <= cfg_data;
        hst_pkg::REG_TURN_X:  cfg_r.turn_x       <= cfg_data;
        hst_pkg::REG_TURN_Y:  cfg_r.turn_y       <= cfg_data;
        hst_pkg::REG_TURN_Z:  cfg_r.turn_z       <= cfg_data;
        hst_pkg::REG_SCALE:   cfg_r.scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // An inverse request with a zero scale is flagged here; the top level forces its result to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid      <= accept;
      ctl_r.inverse    <= in_action;
      ctl_r.zero_scale <= in_action && (cfg_r.scale_factor == '0);
    end
  end

  always_ff @(posedge clk) begin
    p_r <= in_p;
  end

  assign cfg      = cfg_r;
  assign push_ctl = ctl_r;
  assign push_p   = p_r;

endmodule
`default_nettype wire

// File: rtl/hst_queue.sv
// Two-entry request queue between the front end and the arithmetic back end.
`default_nettype none
module hst_queue #(
  parameter int P = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire hst_pkg::item_ctl_t    push_ctl,
  input  wire logic signed [P-1:0]   push_p [3],
  output hst_pkg::item_ctl_t         head_ctl,
  output logic signed [P-1:0]        head_p [3],
  output logic                       full
);

  hst_pkg::item_ctl_t  mem_ctl_r [2];
  logic signed [P-1:0] mem_p_r   [2][3];
  logic                wr_r;
  logic                rd_r;
  logic [1:0]          count_r;
  logic [1:0]          count_nxt;
  logic                pop;

  // The back end takes one request every cycle, so the head leaves as soon as it exists.
  assign pop  = (count_r != 2'd0);
  assign full = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r + {1'b0, push_ctl.valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_ctl.valid) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ctl.valid) begin
      mem_ctl_r[wr_r] <= push_ctl;
      mem_p_r[wr_r]   <= push_p;
    end
  end

  always_comb begin
    head_ctl       = mem_ctl_r[rd_r];
    head_ctl.valid = pop;
  end

  assign head_p = mem_p_r[rd_r];

endmodule
`default_nettype wire

// File: rtl/hst_back.sv
// Back end: rotation, adjugate, determinant and scale products into numerator and denominator.
`default_nettype none
module hst_back #(
  parameter int P = 40,
  parameter int A = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire hst_pkg::cfg_t         cfg,
  input  wire hst_pkg::item_ctl_t    in_ctl,
  input  wire logic signed [P-1:0]   in_p [3],
  output hst_pkg::item_ctl_t         out_ctl,
  output logic signed [hst_pkg::num_width(P, A)-1:0] num [3],
  output logic [hst_pkg::den_width(A)-1:0]           den
);

  localparam int L    = 4;
  localparam int DW   = P + 1;
  localparam int AW   = hst_pkg::adj_width(A);
  localparam int FW   = hst_pkg::rot_width(P, A);
  localparam int DETW = hst_pkg::det_width(A);
  localparam int NW   = hst_pkg::num_width(P, A);
  localparam int DENW = hst_pkg::den_width(A);
  localparam int SF   = hst_pkg::SCALE_FRAC_BITS;

  logic signed [31:0]   w [3];
  logic signed [31:0]   t [3];
  logic signed [32:0]   k [3][3];
  logic signed [32:0]   scale_s;

  hst_pkg::item_ctl_t   ctl_s0_r;
  logic signed [P-1:0]  p_s0_r [3];
  logic signed [DW-1:0] d_s0_r [3];

  hst_pkg::item_ctl_t   ctl_dl_r [L];
  logic signed [P-1:0]  p_dl_r   [L][3];
  logic signed [DW-1:0] d_dl_r   [L][3];

  logic signed [63:0]   ww [3][3];
  logic signed [P+32:0] kp [3][3];

  hst_pkg::item_ctl_t   ctl_c1_r;
  logic signed [AW-1:0] a_c1_r [3][3];
  logic [DETW-1:0]      det_c1_r;
  logic signed [FW-1:0] accf_c1_r [3];
  logic signed [DW-1:0] d_c1_r [3];

  logic signed [AW+DW-1:0]   ad [3][3];
  logic signed [DETW+33:0]   ds;
  logic signed [FW+32:0]     sf [3];
  hst_pkg::item_ctl_t        ctl_dl2_r [L];

  hst_pkg::item_ctl_t        ctl_c2_r;
  logic signed [NW-1:0]      num_r [3];
  logic [DENW-1:0]           den_r;

  assign w[0]    = $signed(cfg.turn_x);
  assign w[1]    = $signed(cfg.turn_y);
  assign w[2]    = $signed(cfg.turn_z);
  assign t[0]    = $signed(cfg.shift_x);
  assign t[1]    = $signed(cfg.shift_y);
  assign t[2]    = $signed(cfg.shift_z);
  assign scale_s = $signed({1'b0, cfg.scale_factor});

  // Skew-symmetric part of the small-angle rotation.
  always_comb begin
    k[0][0] = '0;
    k[0][1] = 33'(w[2]);
    k[0][2] = -33'(w[1]);
    k[1][0] = -33'(w[2]);
    k[1][1] = '0;
    k[1][2] = 33'(w[0]);
    k[2][0] = 33'(w[1]);
    k[2][1] = -33'(w[0]);
    k[2][2] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s0_r <= '0;
    end else begin
      ctl_s0_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_s0_r[i] <= in_p[i];
      d_s0_r[i] <= DW'(in_p[i]) - DW'(t[i]);
    end
  end

  // Item data rides alongside the first multiplier group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < L; s++) begin
        ctl_dl_r[s] <= '0;
      end
    end else begin
      ctl_dl_r[0] <= ctl_s0_r;
      for (int s = 1; s < L; s++) begin
        ctl_dl_r[s] <= ctl_dl_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    p_dl_r[0] <= p_s0_r;
    d_dl_r[0] <= d_s0_r;
    for (int s = 1; s < L; s++) begin
      p_dl_r[s] <= p_dl_r[s-1];
      d_dl_r[s] <= d_dl_r[s-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row_a
    for (genvar j = 0; j < 3; j++) begin : g_col_a
      hst_mul #(.WA(32), .WB(32)) u_ww (
        .clk (clk),
        .a   (w[i]),
        .b   (w[j]),
        .p   (ww[i][j])
      );
      if (i != j) begin : g_kp
        hst_mul #(.WA(33), .WB(P)) u_kp (
          .clk (clk),
          .a   (k[i][j]),
          .b   (p_s0_r[j]),
          .p   (kp[i][j])
        );
      end else begin : g_kp_diag
        assign kp[i][j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c1_r <= '0;
    end else begin
      ctl_c1_r <= ctl_dl_r[L-1];
    end
  end

  // Adjugate is I - K*2^A + w*w^T on the 2^(2A) grid; the determinant is 1 + |w|^2.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a_c1_r[i][j] <= AW'(ww[i][j]) - (AW'(k[i][j]) <<< A)
                        + ((i == j) ? (AW'(1) << (2 * A)) : AW'(0));
      end
      accf_c1_r[i] <= (FW'(p_dl_r[L-1][i]) <<< A) + FW'(kp[i][0]) + FW'(kp[i][1])
                      + FW'(kp[i][2]);
      d_c1_r[i]    <= d_dl_r[L-1][i];
    end
    det_c1_r <= (DETW'(1) << (2 * A)) + DETW'($unsigned(ww[0][0]))
                + DETW'($unsigned(ww[1][1])) + DETW'($unsigned(ww[2][2]));
  end

  for (genvar i = 0; i < 3; i++) begin : g_row_b
    for (genvar j = 0; j < 3; j++) begin : g_col_b
      hst_mul #(.WA(AW), .WB(DW)) u_ad (
        .clk (clk),
        .a   (a_c1_r[i][j]),
        .b   (d_c1_r[j]),
        .p   (ad[i][j])
      );
    end
    hst_mul #(.WA(FW), .WB(33)) u_sf (
      .clk (clk),
      .a   (accf_c1_r[i]),
      .b   (scale_s),
      .p   (sf[i])
    );
  end

  hst_mul #(.WA(DETW + 1), .WB(33)) u_ds (
    .clk (clk),
    .a   ($signed({1'b0, det_c1_r})),
    .b   (scale_s),
    .p   (ds)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < L; s++) begin
        ctl_dl2_r[s] <= '0;
      end
      ctl_c2_r <= '0;
    end else begin
      ctl_dl2_r[0] <= ctl_c1_r;
      for (int s = 1; s < L; s++) begin
        ctl_dl2_r[s] <= ctl_dl2_r[s-1];
      end
      ctl_c2_r <= ctl_dl2_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ctl_dl2_r[L-1].inverse) begin
        num_r[i] <= (NW'(ad[i][0]) + NW'(ad[i][1]) + NW'(ad[i][2])) <<< SF;
      end else begin
        num_r[i] <= (NW'(t[i]) <<< (SF + A)) + NW'(sf[i]);
      end
    end
    den_r <= ctl_dl2_r[L-1].inverse ? ds[DENW-1:0] : (DENW'(1) << (SF + A));
  end

  assign out_ctl = ctl_c2_r;
  assign num     = num_r;
  assign den     = den_r;

endmodule
`default_nettype wire

// File: rtl/hst_div.sv
// Pipelined rounding divider with saturation to the position width.
`default_nettype none
module hst_div #(
  parameter int P    = 40,
  parameter int NW   = 157,
  parameter int DENW = 115
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire hst_pkg::item_ctl_t    in_ctl,
  input  wire logic signed [NW-1:0]  num,
  input  wire logic [DENW-1:0]       den,
  output hst_pkg::item_ctl_t         out_ctl,
  output logic signed [P-1:0]        value,
  output logic                       sat
);

  localparam int QW  = P + 1;
  localparam int NPW = NW + 1;
  localparam int DPW = DENW + 1;
  localparam int CW  = (NPW > DPW + QW) ? NPW : DPW + QW;

  logic [NW-1:0]      mag;
  logic [CW-1:0]      np;
  logic [DPW-1:0]     dd;

  hst_pkg::item_ctl_t ctl_r [QW+1];
  logic [CW-1:0]      rem_r [QW+1];
  logic [QW-1:0]      q_r   [QW+1];
  logic [DPW-1:0]     dd_r  [QW+1];
  logic               neg_r [QW+1];
  logic               ovf_r [QW+1];

  logic [QW-1:0]      maxv;
  logic               sat_pos;
  logic               sat_neg;

  hst_pkg::item_ctl_t out_ctl_r;
  logic signed [P-1:0] value_r;
  logic               sat_r;

  // Rounding to nearest, ties away from zero: q = floor((2|n| + d) / 2d).
  always_comb begin
    mag = $unsigned(num[NW-1] ? -num : num);
    np  = (CW'(mag) << 1) + CW'(den);
    dd  = DPW'(den) << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= np;
    q_r[0]   <= '0;
    dd_r[0]  <= dd;
    neg_r[0] <= num[NW-1];
    ovf_r[0] <= np >= (CW'(dd) << QW);
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int B = QW - s;
    logic [CW-1:0] cand;
    logic          take;

    always_comb begin
      cand = CW'(dd_r[s-1]) << B;
      take = rem_r[s-1] >= cand;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= take ? (rem_r[s-1] - cand) : rem_r[s-1];
      q_r[s]   <= q_r[s-1] | (take ? (QW'(1) << B) : QW'(0));
      dd_r[s]  <= dd_r[s-1];
      neg_r[s] <= neg_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
    end
  end

  always_comb begin
    maxv    = (QW'(1) << (P - 1)) - QW'(1);
    sat_pos = !neg_r[QW] && (ovf_r[QW] || (q_r[QW] > maxv));
    sat_neg = neg_r[QW] && (ovf_r[QW] || (q_r[QW] > maxv + QW'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else begin
      out_ctl_r <= ctl_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_pos || sat_neg;
    if (sat_pos) begin
      value_r <= $signed({1'b0, {(P-1){1'b1}}});
    end else if (sat_neg) begin
      value_r <= $signed({1'b1, {(P-1){1'b0}}});
    end else if (neg_r[QW]) begin
      value_r <= -$signed(q_r[QW][P-1:0]);
    end else begin
      value_r <= $signed(q_r[QW][P-1:0]);
    end
  end

  assign out_ctl = out_ctl_r;
  assign value   = value_r;
  assign sat     = sat_r;

endmodule
`default_nettype wire

// File: rtl/helmert_similarity_transform_unit.sv
// Top level of the seven-parameter Helmert similarity transform unit.
// A request passes through the front-end registers, the request queue, the back-end
// pipeline and the divider's POS_WIDTH + 1 stages before its result is shown.
// Throughput: one request per cycle; busy stays low in normal operation.
// Each result is held on the out_ ports for exactly one cycle under out_valid.
// Reset is synchronous: configuration returns to zero shift, zero turn and unit scale.
`default_nettype none
module helmert_similarity_transform_unit #(
  parameter int POS_WIDTH       = 40,
  parameter int ANGLE_FRAC_BITS = 40
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_action,
  input  wire logic signed [POS_WIDTH-1:0]  in_x,
  input  wire logic signed [POS_WIDTH-1:0]  in_y,
  input  wire logic signed [POS_WIDTH-1:0]  in_z,
  output logic                              out_valid,
  output logic signed [POS_WIDTH-1:0]       out_x,
  output logic signed [POS_WIDTH-1:0]       out_y,
  output logic signed [POS_WIDTH-1:0]       out_z,
  output logic [1:0]                        out_status
);

  localparam int NW   = hst_pkg::num_width(POS_WIDTH, ANGLE_FRAC_BITS);
  localparam int DENW = hst_pkg::den_width(ANGLE_FRAC_BITS);

  logic signed [POS_WIDTH-1:0] in_p [3];
  hst_pkg::cfg_t               cfg;
  hst_pkg::item_ctl_t          push_ctl;
  logic signed [POS_WIDTH-1:0] push_p [3];
  hst_pkg::item_ctl_t          head_ctl;
  logic signed [POS_WIDTH-1:0] head_p [3];
  logic                        q_full;
  hst_pkg::item_ctl_t          back_ctl;
  logic signed [NW-1:0]        num [3];
  logic [DENW-1:0]             den;
  hst_pkg::item_ctl_t          div_ctl [3];
  logic signed [POS_WIDTH-1:0] div_val [3];
  logic                        div_sat [3];
  logic                        zero_res;

  assign in_p[0] = in_x;
  assign in_p[1] = in_y;
  assign in_p[2] = in_z;

  hst_front #(.P(POS_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .q_full    (q_full),
    .in_action (in_action),
    .in_p      (in_p),
    .busy      (busy),
    .cfg       (cfg),
    .push_ctl  (push_ctl),
    .push_p    (push_p)
  );

  hst_queue #(.P(POS_WIDTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_ctl (push_ctl),
    .push_p   (push_p),
    .head_ctl (head_ctl),
    .head_p   (head_p),
    .full     (q_full)
  );

  hst_back #(.P(POS_WIDTH), .A(ANGLE_FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ctl  (head_ctl),
    .in_p    (head_p),
    .out_ctl (back_ctl),
    .num     (num),
    .den     (den)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    hst_div #(.P(POS_WIDTH), .NW(NW), .DENW(DENW)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (back_ctl),
      .num     (num[i]),
      .den     (den),
      .out_ctl (div_ctl[i]),
      .value   (div_val[i]),
      .sat     (div_sat[i])
    );
  end

  assign zero_res  = div_ctl[0].zero_scale;
  assign out_valid = div_ctl[0].valid;
  assign out_x     = zero_res ? '0 : div_val[0];
  assign out_y     = zero_res ? '0 : div_val[1];
  assign out_z     = zero_res ? '0 : div_val[2];

  always_comb begin
    if (zero_res) begin
      out_status = hst_pkg::STATUS_ZERO_SCALE;
    end else if (div_sat[0] || div_sat[1] || div_sat[2]) begin
      out_status = hst_pkg::STATUS_SATURATED;
    end else begin
      out_status = hst_pkg::STATUS_OK;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != hst_pkg::STATUS_UNUSED))
    else $error("unused status code on a result");

  a_zero_scale_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == hst_pkg::STATUS_ZERO_SCALE))
      |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("zero-scale result carries nonzero coordinates");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_ctl[0] == div_ctl[1]) && (div_ctl[1] == div_ctl[2]))
    else $error("divider lanes out of step");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the Helmert similarity transform unit.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 70;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic                 action;
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
  } position_t;

  typedef struct {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
    logic [1:0]           status;
  } fix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic start = 1'b0;
  logic in_action = 1'b0;
  logic signed [PW-1:0] in_x = '0;
  logic signed [PW-1:0] in_y = '0;
  logic signed [PW-1:0] in_z = '0;
  logic busy;
  logic out_valid;
  logic signed [PW-1:0] out_x;
  logic signed [PW-1:0] out_y;
  logic signed [PW-1:0] out_z;
  logic [1:0] out_status;

  position_t pending_positions[$];
  fix_t expected_fixes[$];
  logic [31:0] datum[7];
  int gap = 0;
  bit quiet = 1'b0;
  int errors = 0;
  int cycles = 0;

  helmert_similarity_transform_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_action(in_action), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Rounds num/den to nearest, ties away from zero, then clamps to the port width.
  function automatic logic signed [PW-1:0] round_clamp(wide_t num, wide_t den,
                                                       inout bit sat);
    wide_t mag;
    wide_t q;
    wide_t r;
    wide_t maxv;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    if ((r <<< 1) >= den) q = q + 1;
    maxv = (wide_t'(1) <<< (PW - 1)) - 1;
    if (neg) begin
      if (q > maxv + 1) begin
        sat = 1'b1;
        return {1'b1, {(PW-1){1'b0}}};
      end
      return -q[PW-1:0];
    end
    if (q > maxv) begin
      sat = 1'b1;
      return {1'b0, {(PW-1){1'b1}}};
    end
    return q[PW-1:0];
  endfunction

  function automatic fix_t helmert_fix(position_t pos);
    wide_t p[3], t[3], w[3], k[3][3], d[3];
    wide_t s, den, acc, det, unit, a;
    logic signed [PW-1:0] r[3];
    bit sat;
    fix_t f;
    sat = 1'b0;
    p[0] = pos.x; p[1] = pos.y; p[2] = pos.z;
    for (int i = 0; i < 3; i++) begin
      t[i] = $signed(datum[i]);
      w[i] = $signed(datum[3 + i]);
      for (int j = 0; j < 3; j++) k[i][j] = '0;
    end
    s = {224'b0, datum[hst_pkg::REG_SCALE]};
    k[0][1] = w[2];  k[0][2] = -w[1];
    k[1][0] = -w[2]; k[1][2] = w[0];
    k[2][0] = w[1];  k[2][1] = -w[0];
    if (pos.action && datum[hst_pkg::REG_SCALE] == 0) begin
      f.x = '0; f.y = '0; f.z = '0;
      f.status = hst_pkg::STATUS_ZERO_SCALE;
      return f;
    end
    if (!pos.action) begin
      den = wide_t'(1) <<< 70;
      for (int i = 0; i < 3; i++) begin
        acc = p[i] <<< 40;
        for (int j = 0; j < 3; j++)
          if (j != i) acc = acc + k[i][j] * p[j];
        r[i] = round_clamp((t[i] <<< 70) + s * acc, den, sat);
      end
    end else begin
      unit = wide_t'(1) <<< 80;
      det = unit;
      for (int i = 0; i < 3; i++) begin
        det = det + w[i] * w[i];
        d[i] = p[i] - t[i];
      end
      den = det * s;
      for (int i = 0; i < 3; i++) begin
        acc = '0;
        for (int j = 0; j < 3; j++) begin
          a = w[i] * w[j] - (k[i][j] <<< 40);
          if (i == j) a = a + unit;
          acc = acc + a * d[j];
        end
        r[i] = round_clamp(acc <<< 30, den, sat);
      end
    end
    f.x = r[0]; f.y = r[1]; f.z = r[2];
    f.status = sat ? hst_pkg::STATUS_SATURATED : hst_pkg::STATUS_OK;
    return f;
  endfunction

  function automatic logic signed [PW-1:0] pick_coord();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return raw[PW-1:0];
      1: return PW'($signed(raw[20:0]));
      2: return PW'($signed(raw[31:0]));
      3: return raw[0] ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
      default: return PW'($signed(raw[36:0]));
    endcase
  endfunction

  function automatic logic [31:0] pick_turn();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 3))
      0: return raw;
      1: return 32'($signed(raw[12:0]));
      default: return 32'($signed(raw[24:0]));
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 3));
      default: return hst_pkg::SCALE_ONE + 32'($signed(12'($urandom)));
    endcase
  endfunction

  task automatic queue_position(logic act, logic signed [PW-1:0] x,
                                logic signed [PW-1:0] y, logic signed [PW-1:0] z);
    position_t pos;
    pos.action = act; pos.x = x; pos.y = y; pos.z = z;
    pending_positions.push_back(pos);
  endtask

  task automatic queue_random(int count);
    for (int n = 0; n < count; n++)
      queue_position(1'($urandom), pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx < 3'd7) datum[idx] = value;
  endtask

  task automatic write_datum(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                             logic [31:0] sc);
    write_reg(hst_pkg::REG_SHIFT_X, sx);
    write_reg(hst_pkg::REG_SHIFT_Y, sy);
    write_reg(hst_pkg::REG_SHIFT_Z, sz);
    write_reg(hst_pkg::REG_TURN_X, tx);
    write_reg(hst_pkg::REG_TURN_Y, ty);
    write_reg(hst_pkg::REG_TURN_Z, tz);
    write_reg(hst_pkg::REG_SCALE, sc);
  endtask

  // Blocks until every queued request has been taken and answered.
  task automatic drain();
    do @(posedge clk);
    while (pending_positions.size() != 0 || start || expected_fixes.size() != 0);
  endtask

  always @(posedge clk) begin : driver
    position_t pos;
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      if (start && !busy) begin
        pos.action = in_action; pos.x = in_x; pos.y = in_y; pos.z = in_z;
        expected_fixes.push_back(helmert_fix(pos));
      end
      if (!start || !busy) begin
        if (gap != 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (pending_positions.size() != 0) begin
          pos = pending_positions.pop_front();
          in_action <= pos.action;
          in_x <= pos.x;
          in_y <= pos.y;
          in_z <= pos.z;
          start <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 9);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    fix_t want;
    if (rst_n && out_valid) begin
      if (expected_fixes.size() == 0) begin
        $display("%0t: result with no request pending: %h %h %h status %0d",
                 $time, out_x, out_y, out_z, out_status);
        errors++;
      end else begin
        want = expected_fixes.pop_front();
        if (out_x !== want.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_x);
          errors++;
        end
        if (out_y !== want.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_y);
          errors++;
        end
        if (out_z !== want.z) begin
          $display("%0t: out_z expected %0d actual %0d", $time, want.z, out_z);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: out_status expected %0d actual %0d", $time, want.status,
                   out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** helmert_similarity_transform_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic signed [PW-1:0] top;
    logic signed [PW-1:0] bot;
    top = {1'b0, {(PW-1){1'b1}}};
    bot = {1'b1, {(PW-1){1'b0}}};
    for (int i = 0; i < 7; i++) datum[i] = '0;
    datum[hst_pkg::REG_SCALE] = hst_pkg::SCALE_ONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Identity datum after reset: field extremes on both paths.
    for (int a = 0; a < 2; a++) begin
      queue_position(a[0], '0, '0, '0);
      queue_position(a[0], top, bot, top);
      queue_position(a[0], bot, top, bot);
      queue_position(a[0], -1, 1, PW'(-2));
      queue_position(a[0], PW'(40'h55_5555_5555), PW'(40'haa_aaaa_aaaa), 12345);
    end
    drain();

    // Large shifts and turns push both paths into saturation.
    write_datum(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    queue_position(1'b0, top, top, top);
    queue_position(1'b1, bot, bot, bot);
    queue_position(1'b0, '0, '0, '0);
    queue_random(150);
    drain();

    // Zero scale: forward gives the shift, inverse reports the error.
    write_datum(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    queue_position(1'b0, top, bot, '0);
    queue_position(1'b1, top, bot, '0);
    queue_random(150);
    drain();

    // A write past the last register must leave the datum alone.
    write_datum(32'd1000, -32'sd2000, 32'd3, 32'd5000, -32'sd7000, 32'd9,
                hst_pkg::SCALE_ONE);
    write_reg(REG_NONE, 32'h0);
    queue_random(150);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_datum($urandom, $urandom, $urandom, pick_turn(), pick_turn(), pick_turn(),
                  pick_scale());
      if (ph == 7) quiet = 1'b1;
      queue_random(160);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_fixes.size() == 0) begin
      $display("** helmert_similarity_transform_unit: PASSED **");
    end else begin
      $display("** helmert_similarity_transform_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
